>>> hw/rtl/vfpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vfpb_pkg;

  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int RW       = 31;
  localparam int IN_W     = 12 * CW;
  localparam int OUT_W    = 4 * CW;
  localparam int OUT_UW   = 4;
  localparam int VW       = 63;
  localparam int MW       = 62;
  localparam int MSBW     = 6;
  localparam int NGRP     = 8;
  localparam int GW       = 3;
  localparam int EGRP     = CW / 8;
  localparam int EGW      = 2;
  localparam int EMSBW    = 5;
  localparam int SC_MSB   = 29;
  localparam int SC_W     = 30;
  localparam int SQ_STEPS = 32;
  localparam int SQW      = 64;
  localparam int QW       = 18;
  localparam int NUMW     = 48;
  localparam int NORM_LAT = 58;

  localparam logic [RW-1:0] NEAR_RST   = RW'(6554);
  localparam logic [RW-1:0] FAR_RST    = RW'(65536000);
  localparam logic [RW-1:0] TAN_RST    = RW'(27146);
  localparam logic [RW-1:0] ASPECT_RST = RW'(65536);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [2:0][CW-1:0] cvec_t;
  typedef logic [2:0][VW-1:0] nvec_t;

  typedef struct packed {
    logic            neg;
    logic [2*CW-1:0] mag;
  } mprod_t;

  typedef enum logic [1:0] {
    REG_NEAR   = 2'd0,
    REG_FAR    = 2'd1,
    REG_TAN    = 2'd2,
    REG_ASPECT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PL_LEFT   = 3'd0,
    PL_BOTTOM = 3'd1,
    PL_RIGHT  = 3'd2,
    PL_TOP    = 3'd3,
    PL_NEAR   = 3'd4,
    PL_FAR    = 3'd5
  } plane_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic mprod_t mul_mag(coord_t a, coord_t b);
    logic [CW-1:0] ma;
    logic [CW-1:0] mb;
    mprod_t p;
    ma = a[CW-1] ? CW'(-a) : CW'(a);
    mb = b[CW-1] ? CW'(-b) : CW'(b);
    p.neg = a[CW-1] ^ b[CW-1];
    p.mag = (2*CW)'(ma) * (2*CW)'(mb);
    return p;
  endfunction

  function automatic coord_t mul_round(mprod_t p);
    logic [2*CW-1:0] r;
    logic [2*CW-1:0] nr;
    coord_t res;
    r  = (p.mag + ((2*CW)'(1) << (FB-1))) >> FB;
    nr = -r;
    if (p.neg) begin
      if (r > ((2*CW)'(1) << (CW-1))) res = CMIN;
      else res = nr[CW-1:0];
    end else begin
      if (r > (2*CW)'(CMAX)) res = CMAX;
      else res = r[CW-1:0];
    end
    return res;
  endfunction

  function automatic coord_t sat1(logic [CW:0] s);
    coord_t res;
    if (s[CW] != s[CW-1]) res = s[CW] ? CMIN : CMAX;
    else res = s[CW-1:0];
    return res;
  endfunction

  function automatic coord_t add_sat(coord_t a, coord_t b);
    return sat1({a[CW-1], a} + {b[CW-1], b});
  endfunction

  function automatic coord_t sub_sat(coord_t a, coord_t b);
    return sat1({a[CW-1], a} - {b[CW-1], b});
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vfpb_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module vfpb_norm (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire vfpb_pkg::nvec_t v_i,
  output vfpb_pkg::cvec_t     n_o,
  output logic                ok_o
);
  import vfpb_pkg::*;

  logic [2:0]            neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [2:0][MW-1:0]    m1_r, m2_r, m3_r;
  logic [NGRP*8-1:0]     or2_r;
  logic [GW-1:0]         grp2_r;
  logic                  zero2_r, zero3_r, zero4_r, zero5_r;
  logic [MSBW-1:0]       msb3_r;
  logic [2:0][SC_W-1:0]  m4_r, m5_r;
  logic [2:0][2*SC_W-1:0] sq5_r;

  logic [SQW-1:0]        sx_r [SQ_STEPS+1];
  logic [SQW-1:0]        sr_r [SQ_STEPS+1];
  logic [2:0]            sn_r [SQ_STEPS+1];
  logic [2:0][SC_W-1:0]  sm_r [SQ_STEPS+1];
  logic                  sz_r [SQ_STEPS+1];

  logic [2:0][NUMW-1:0]  dr_r [QW+1];
  logic [2:0][QW-1:0]    dq_r [QW+1];
  logic [CW-1:0]         dd_r [QW+1];
  logic [2:0]            dn_r [QW+1];
  logic                  dz_r [QW+1];

  cvec_t                 n_r;
  logic                  ok_r;

  logic [NGRP*8-1:0]     orp;
  logic [GW-1:0]         grp;
  logic [7:0]            byt;
  logic [2:0]            bp;
  logic [CW-1:0]         len;

  always_comb begin
    orp = (NGRP*8)'(m1_r[0] | m1_r[1] | m1_r[2]);
    grp = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (|orp[g*8 +: 8]) grp = GW'(g);
    end
    byt = or2_r[{grp2_r, 3'b000} +: 8];
    bp  = '0;
    for (int b = 0; b < 8; b++) begin
      if (byt[b]) bp = 3'(b);
    end
    len = sr_r[SQ_STEPS][CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= v_i[i][VW-1];
        m1_r[i]   <= v_i[i][VW-1] ? MW'(-v_i[i]) : MW'(v_i[i]);
      end
      neg2_r  <= neg1_r;
      m2_r    <= m1_r;
      or2_r   <= orp;
      grp2_r  <= grp;
      zero2_r <= (orp == '0);
      neg3_r  <= neg2_r;
      m3_r    <= m2_r;
      msb3_r  <= {grp2_r, bp};
      zero3_r <= zero2_r;
      for (int i = 0; i < 3; i++) begin
        if (msb3_r > MSBW'(SC_MSB)) m4_r[i] <= SC_W'(m3_r[i] >> (msb3_r - MSBW'(SC_MSB)));
        else m4_r[i] <= SC_W'(m3_r[i] << (MSBW'(SC_MSB) - msb3_r));
      end
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= (2*SC_W)'(m4_r[i]) * (2*SC_W)'(m4_r[i]);
      end
      m5_r    <= m4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
      sx_r[0] <= SQW'(sq5_r[0]) + SQW'(sq5_r[1]) + SQW'(sq5_r[2]);
      sr_r[0] <= '0;
      sn_r[0] <= neg5_r;
      sm_r[0] <= m5_r;
      sz_r[0] <= zero5_r;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQW-1:0] t;
    assign t = sr_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sx_r[j] >= t) begin
          sx_r[j+1] <= sx_r[j] - t;
          sr_r[j+1] <= (sr_r[j] >> 1) + BIT;
        end else begin
          sx_r[j+1] <= sx_r[j];
          sr_r[j+1] <= sr_r[j] >> 1;
        end
        sn_r[j+1] <= sn_r[j];
        sm_r[j+1] <= sm_r[j];
        sz_r[j+1] <= sz_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dr_r[0][i] <= (NUMW'(sm_r[SQ_STEPS][i]) << FB) + NUMW'(len >> 1);
      end
      dq_r[0] <= '0;
      dd_r[0] <= len;
      dn_r[0] <= sn_r[SQ_STEPS];
      dz_r[0] <= sz_r[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NUMW-1:0] trial;
    assign trial = NUMW'(dd_r[k]) << (QW - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dr_r[k][i] >= trial) begin
            dr_r[k+1][i] <= dr_r[k][i] - trial;
            dq_r[k+1][i] <= dq_r[k][i] | (QW'(1) << (QW - 1 - k));
          end else begin
            dr_r[k+1][i] <= dr_r[k][i];
            dq_r[k+1][i] <= dq_r[k][i];
          end
        end
        dd_r[k+1] <= dd_r[k];
        dn_r[k+1] <= dn_r[k];
        dz_r[k+1] <= dz_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dz_r[QW]) n_r[i] <= '0;
        else if (dn_r[QW][i]) n_r[i] <= -CW'(dq_r[QW][i]);
        else n_r[i] <= CW'(dq_r[QW][i]);
      end
      ok_r <= !dz_r[QW];
    end
  end

  assign n_o  = n_r;
  assign ok_o = ok_r;

endmodule
`default_nettype wire

>>> hw/rtl/view_frustum_plane_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// Each pose gives six plane beats, one plane per cycle while out_tready does not stall them.
// The pose front pipelines poses but holds in_tready low while a pose waits on the plane path;
// a single plane path (edge scaling, sqrt and divide pipeline) takes one plane per cycle unless stalled.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
module view_frustum_plane_builder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z, right_x, right_y, right_z
  input  wire logic [vfpb_pkg::IN_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // normal_x, normal_y, normal_z, plane_offset
  output logic [vfpb_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tlast,
  // plane_index, degenerate
  output logic [vfpb_pkg::OUT_UW-1:0]       out_tuser,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_addr,
  input  wire logic [vfpb_pkg::RW-1:0]      cfg_wdata
);
  import vfpb_pkg::*;

  logic [RW-1:0] near_r, far_r, tan_r, asp_r;
  mprod_t        kp_r [2];
  mprod_t        kq_r [2];
  coord_t        yh_r [2];
  coord_t        xh_r [2];
  coord_t        clip_d [2];

  logic          en_f, en_p;
  cvec_t         in_pos, in_up, in_rt;
  nvec_t         in_fwd;
  cvec_t         f_n;
  logic          f_ok;

  logic          fv_r   [NORM_LAT];
  cvec_t         fpos_r [NORM_LAT];
  cvec_t         fup_r  [NORM_LAT];
  cvec_t         frt_r  [NORM_LAT];

  logic          c1_vld_r, c2_vld_r, c3_vld_r, c4_vld_r, c5_vld_r;
  mprod_t        pf_r [2][3];
  mprod_t        px_r [2][3];
  mprod_t        py_r [2][3];
  cvec_t         c1pos_r, c2pos_r;
  coord_t        tf_r [2][3];
  coord_t        tx_r [2][3];
  coord_t        ty_r [2][3];
  coord_t        c3x_r [2][3];
  coord_t        c3y_r [2][3];
  coord_t        c4y_r [2][3];
  coord_t        cen_r [2][3];
  coord_t        h_r   [8][3];
  cvec_t         cor_r [8];

  plane_t        cnt_r;
  cvec_t         sc, sa, sb;
  logic          p0_vld_r, p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r, p5_vld_r, p6_vld_r;
  cvec_t         p0c_r, p0a_r, p0b_r;
  plane_t        p0i_r, p1i_r, p2i_r, p3i_r, p4i_r, p5i_r, p6i_r;
  cvec_t         p1c_r, p2c_r, p3c_r, p4c_r, p5c_r, p6c_r;
  coord_t        d_r [2][3];
  logic [CW-1:0] em2_r [2][3];
  logic [CW-1:0] em3_r [2][3];
  logic          en2_r [2][3];
  logic          en3_r [2][3];
  logic [CW-1:0] eor_r [2];
  logic [EGW-1:0] eg_r [2];
  logic [EGW-1:0] eg_c [2];
  logic [EMSBW-1:0] eb_c [2];
  logic [CW-1:0] eor_c [2];
  logic [7:0]    ebyt [2];
  logic signed [SC_W:0] s_r [2][3];
  logic signed [2*SC_W+1:0] cp_r [6];
  logic signed [VW-1:0] cr_r [3];
  nvec_t         cr_v;

  logic          pd_v_r [NORM_LAT];
  cvec_t         pd_c_r [NORM_LAT];
  plane_t        pd_i_r [NORM_LAT];
  cvec_t         nv;
  logic          nv_ok;

  logic          q1_vld_r, q2_vld_r, out_vld_r;
  mprod_t        dp_r [3];
  coord_t        qd_r [3];
  cvec_t         q1n_r, q2n_r, on_r;
  logic          q1ok_r, q2ok_r;
  plane_t        q1i_r, q2i_r, oi_r;
  coord_t        off_r;
  logic          odeg_r;
  logic signed [CW+1:0] dsum, dneg;
  coord_t        off_c;

  assign en_f      = !c5_vld_r || (en_p && cnt_r == PL_FAR);
  assign en_p      = !out_vld_r || out_tready;
  assign in_tready = en_f;

  always_comb begin
    clip_d[0] = {1'b0, near_r};
    clip_d[1] = {1'b0, far_r};
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = in_tdata[i*CW +: CW];
      in_fwd[i] = {{(VW-CW){in_tdata[(3+i)*CW + CW-1]}}, in_tdata[(3+i)*CW +: CW]};
      in_up[i]  = in_tdata[(6+i)*CW +: CW];
      in_rt[i]  = in_tdata[(9+i)*CW +: CW];
      cr_v[i]   = cr_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      kp_r[k] <= mul_mag(clip_d[k], {1'b0, tan_r});
      yh_r[k] <= mul_round(kp_r[k]);
      kq_r[k] <= mul_mag(yh_r[k], {1'b0, asp_r});
      xh_r[k] <= mul_round(kq_r[k]);
    end
  end

  vfpb_norm u_fwd_norm (
    .clk  (clk),
    .en   (en_f),
    .v_i  (in_fwd),
    .n_o  (f_n),
    .ok_o (f_ok)
  );

  vfpb_norm u_plane_norm (
    .clk  (clk),
    .en   (en_p),
    .v_i  (cr_v),
    .n_o  (nv),
    .ok_o (nv_ok)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r    <= NEAR_RST;
      far_r     <= FAR_RST;
      tan_r     <= TAN_RST;
      asp_r     <= ASPECT_RST;
      for (int k = 0; k < NORM_LAT; k++) begin
        fv_r[k]   <= 1'b0;
        pd_v_r[k] <= 1'b0;
      end
      c1_vld_r  <= 1'b0;
      c2_vld_r  <= 1'b0;
      c3_vld_r  <= 1'b0;
      c4_vld_r  <= 1'b0;
      c5_vld_r  <= 1'b0;
      cnt_r     <= PL_LEFT;
      p0_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
      p5_vld_r  <= 1'b0;
      p6_vld_r  <= 1'b0;
      q1_vld_r  <= 1'b0;
      q2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_NEAR:   near_r <= cfg_wdata;
          REG_FAR:    far_r  <= cfg_wdata;
          REG_TAN:    tan_r  <= cfg_wdata;
          REG_ASPECT: asp_r  <= cfg_wdata;
          default:    near_r <= near_r;
        endcase
      end
      if (en_f) begin
        fv_r[0] <= in_tvalid;
        for (int k = 1; k < NORM_LAT; k++) fv_r[k] <= fv_r[k-1];
        c1_vld_r <= fv_r[NORM_LAT-1];
        c2_vld_r <= c1_vld_r;
        c3_vld_r <= c2_vld_r;
        c4_vld_r <= c3_vld_r;
        c5_vld_r <= c4_vld_r;
      end
      if (en_p) begin
        if (c5_vld_r) cnt_r <= (cnt_r == PL_FAR) ? PL_LEFT : plane_t'(cnt_r + 3'd1);
        p0_vld_r  <= c5_vld_r;
        p1_vld_r  <= p0_vld_r;
        p2_vld_r  <= p1_vld_r;
        p3_vld_r  <= p2_vld_r;
        p4_vld_r  <= p3_vld_r;
        p5_vld_r  <= p4_vld_r;
        p6_vld_r  <= p5_vld_r;
        pd_v_r[0] <= p6_vld_r;
        for (int k = 1; k < NORM_LAT; k++) pd_v_r[k] <= pd_v_r[k-1];
        q1_vld_r  <= pd_v_r[NORM_LAT-1];
        q2_vld_r  <= q1_vld_r;
        out_vld_r <= q2_vld_r;
      end
    end
  end

  // pose front: forward normalize, centers, corners
  always_ff @(posedge clk) begin
    if (en_f) begin
      fpos_r[0] <= in_pos;
      fup_r[0]  <= in_up;
      frt_r[0]  <= in_rt;
      for (int k = 1; k < NORM_LAT; k++) begin
        fpos_r[k] <= fpos_r[k-1];
        fup_r[k]  <= fup_r[k-1];
        frt_r[k]  <= frt_r[k-1];
      end
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          pf_r[k][i]  <= mul_mag(f_n[i], clip_d[k]);
          px_r[k][i]  <= mul_mag(xh_r[k], frt_r[NORM_LAT-1][i]);
          py_r[k][i]  <= mul_mag(yh_r[k], fup_r[NORM_LAT-1][i]);
          tf_r[k][i]  <= mul_round(pf_r[k][i]);
          tx_r[k][i]  <= mul_round(px_r[k][i]);
          ty_r[k][i]  <= mul_round(py_r[k][i]);
          cen_r[k][i] <= add_sat(c2pos_r[i], tf_r[k][i]);
          c3x_r[k][i] <= tx_r[k][i];
          c3y_r[k][i] <= ty_r[k][i];
          c4y_r[k][i] <= c3y_r[k][i];
        end
      end
      c1pos_r <= fpos_r[NORM_LAT-1];
      c2pos_r <= c1pos_r;
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 3; i++) begin
          if ((k & 2) != 0) h_r[k][i] <= add_sat(cen_r[k>>2][i], c3x_r[k>>2][i]);
          else h_r[k][i] <= sub_sat(cen_r[k>>2][i], c3x_r[k>>2][i]);
          if ((k & 1) != 0) cor_r[k][i] <= add_sat(h_r[k][i], c4y_r[k>>2][i]);
          else cor_r[k][i] <= sub_sat(h_r[k][i], c4y_r[k>>2][i]);
        end
      end
    end
  end

  always_comb begin
    sc = '0;
    sa = '0;
    sb = '0;
    unique case (cnt_r)
      PL_LEFT:   begin sc = cor_r[4]; sa = cor_r[5]; sb = cor_r[0]; end
      PL_BOTTOM: begin sc = cor_r[6]; sa = cor_r[4]; sb = cor_r[2]; end
      PL_RIGHT:  begin sc = cor_r[7]; sa = cor_r[6]; sb = cor_r[3]; end
      PL_TOP:    begin sc = cor_r[5]; sa = cor_r[7]; sb = cor_r[1]; end
      PL_NEAR:   begin sc = cor_r[3]; sa = cor_r[2]; sb = cor_r[1]; end
      PL_FAR:    begin sc = cor_r[7]; sa = cor_r[5]; sb = cor_r[6]; end
      default:   begin sc = '0; sa = '0; sb = '0; end
    endcase
  end

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      eor_c[v] = em2_r[v][0] | em2_r[v][1] | em2_r[v][2];
      eg_c[v]  = '0;
      for (int g = 0; g < EGRP; g++) begin
        if (|eor_c[v][g*8 +: 8]) eg_c[v] = EGW'(g);
      end
      ebyt[v] = eor_r[v][{eg_r[v], 3'b000} +: 8];
      eb_c[v] = {eg_r[v], 3'b000};
      for (int b = 0; b < 8; b++) begin
        if (ebyt[v][b]) eb_c[v] = {eg_r[v], 3'(b)};
      end
    end
  end

  always_comb begin
    dsum  = (CW+2)'(qd_r[0]) + (CW+2)'(qd_r[1]) + (CW+2)'(qd_r[2]);
    dneg  = -dsum;
    if (dneg[CW+1:CW-1] == 3'b000 || dneg[CW+1:CW-1] == 3'b111) off_c = dneg[CW-1:0];
    else off_c = dneg[CW+1] ? CMIN : CMAX;
  end

  // plane path
  always_ff @(posedge clk) begin
    if (en_p) begin
      p0c_r <= sc;
      p0a_r <= sa;
      p0b_r <= sb;
      p0i_r <= cnt_r;
      for (int i = 0; i < 3; i++) begin
        d_r[0][i] <= sub_sat(p0a_r[i], p0c_r[i]);
        d_r[1][i] <= sub_sat(p0b_r[i], p0c_r[i]);
      end
      p1c_r <= p0c_r;
      p1i_r <= p0i_r;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          em2_r[v][i] <= d_r[v][i][CW-1] ? CW'(-d_r[v][i]) : CW'(d_r[v][i]);
          en2_r[v][i] <= d_r[v][i][CW-1];
          em3_r[v][i] <= em2_r[v][i];
          en3_r[v][i] <= en2_r[v][i];
          if (eb_c[v] > EMSBW'(SC_MSB))
            s_r[v][i] <= en3_r[v][i]
                ? -$signed({1'b0, SC_W'(em3_r[v][i] >> (eb_c[v] - EMSBW'(SC_MSB)))})
                : $signed({1'b0, SC_W'(em3_r[v][i] >> (eb_c[v] - EMSBW'(SC_MSB)))});
          else
            s_r[v][i] <= en3_r[v][i]
                ? -$signed({1'b0, SC_W'(em3_r[v][i] << (EMSBW'(SC_MSB) - eb_c[v]))})
                : $signed({1'b0, SC_W'(em3_r[v][i] << (EMSBW'(SC_MSB) - eb_c[v]))});
        end
        eor_r[v] <= eor_c[v];
        eg_r[v]  <= eg_c[v];
      end
      p2c_r <= p1c_r;
      p2i_r <= p1i_r;
      p3c_r <= p2c_r;
      p3i_r <= p2i_r;
      p4c_r <= p3c_r;
      p4i_r <= p3i_r;
      cp_r[0] <= s_r[0][1] * s_r[1][2];
      cp_r[1] <= s_r[0][2] * s_r[1][1];
      cp_r[2] <= s_r[0][2] * s_r[1][0];
      cp_r[3] <= s_r[0][0] * s_r[1][2];
      cp_r[4] <= s_r[0][0] * s_r[1][1];
      cp_r[5] <= s_r[0][1] * s_r[1][0];
      p5c_r <= p4c_r;
      p5i_r <= p4i_r;
      cr_r[0] <= cp_r[0] - cp_r[1];
      cr_r[1] <= cp_r[2] - cp_r[3];
      cr_r[2] <= cp_r[4] - cp_r[5];
      p6c_r <= p5c_r;
      p6i_r <= p5i_r;
      pd_c_r[0] <= p6c_r;
      pd_i_r[0] <= p6i_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        pd_c_r[k] <= pd_c_r[k-1];
        pd_i_r[k] <= pd_i_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= mul_mag(nv[i], pd_c_r[NORM_LAT-1][i]);
        qd_r[i] <= mul_round(dp_r[i]);
      end
      q1n_r  <= nv;
      q1ok_r <= nv_ok;
      q1i_r  <= pd_i_r[NORM_LAT-1];
      q2n_r  <= q1n_r;
      q2ok_r <= q1ok_r;
      q2i_r  <= q1i_r;
      on_r   <= q2n_r;
      off_r  <= off_c;
      oi_r   <= q2i_r;
      odeg_r <= !q2ok_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {off_r, on_r[2], on_r[1], on_r[0]};
  assign out_tuser  = {odeg_r, oi_r};
  assign out_tlast  = (oi_r == PL_FAR);

  logic unused_ok;
  assign unused_ok = f_ok;

endmodule
`default_nettype wire

>>> dv/tb_view_frustum_plane_builder.sv
`timescale 1ns / 1ps
module tb_view_frustum_plane_builder;
  import vfpb_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [31:0] off;
    logic        degen;
    logic        last;
  } plane_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic [OUT_UW-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [RW-1:0] cfg_wdata = '0;

  view_frustum_plane_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  logic [IN_W-1:0] pose_q[$];
  plane_beat_t plane_q[$];
  longint near_d = 6554, far_d = 65536000, tan_h = 27146, aspect = 65536;
  int errors = 0;
  int poses_sent = 0;
  int planes_seen = 0;
  int degen_seen = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clamp(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [127:0] p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = ({64'd0, ua} * {64'd0, ub} + 128'd32768) >> FB;
    if ((a < 0) != (b < 0)) begin
      if (p > 128'd2147483648) return QMIN;
      return -longint'(p[63:0]);
    end
    if (p > 128'd2147483647) return QMAX;
    return longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift magnitudes together so the largest lands in [2^29, 2^30)
  task automatic fit_range(input longint v0, v1, v2, output logic [63:0] m0, m1, m2,
                           output bit ok);
    logic [63:0] mx;
    m0 = (v0 < 0) ? -v0 : v0;
    m1 = (v1 < 0) ? -v1 : v1;
    m2 = (v2 < 0) ? -v2 : v2;
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    ok = (mx != 0);
    if (ok) begin
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1; m0 = m0 << 1; m1 = m1 << 1; m2 = m2 << 1;
      end
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1; m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1;
      end
    end
  endtask

  task automatic scale_vec(input longint v[3], output longint o[3]);
    logic [63:0] m0, m1, m2;
    bit ok;
    fit_range(v[0], v[1], v[2], m0, m1, m2, ok);
    o[0] = ok ? ((v[0] < 0) ? -longint'(m0) : longint'(m0)) : 0;
    o[1] = ok ? ((v[1] < 0) ? -longint'(m1) : longint'(m1)) : 0;
    o[2] = ok ? ((v[2] < 0) ? -longint'(m2) : longint'(m2)) : 0;
  endtask

  task automatic unit_vec(input longint v[3], output longint o[3], output bit ok);
    logic [63:0] m[3];
    logic [63:0] len;
    logic [63:0] q;
    fit_range(v[0], v[1], v[2], m[0], m[1], m[2], ok);
    len = ok ? root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) : 64'd1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + len / 2) / len;
      o[i] = !ok ? 0 : ((v[i] < 0) ? -longint'(q) : longint'(q));
    end
  endtask

  function automatic int plane_corner(int p, int j);
    case (p)
      PL_LEFT:   return (j == 0) ? 4 : (j == 1) ? 5 : 0;
      PL_BOTTOM: return (j == 0) ? 6 : (j == 1) ? 4 : 2;
      PL_RIGHT:  return (j == 0) ? 7 : (j == 1) ? 6 : 3;
      PL_TOP:    return (j == 0) ? 5 : (j == 1) ? 7 : 1;
      PL_NEAR:   return (j == 0) ? 3 : (j == 1) ? 2 : 1;
      default:   return (j == 0) ? 7 : (j == 1) ? 5 : 6;
    endcase
  endfunction

  task automatic predict_planes(input logic [IN_W-1:0] d);
    longint pos[3], fwd[3], up[3], rt[3], f[3];
    longint crn[8][3];
    longint cd[2], yh[2], xh[2];
    longint d0[3], d1[3], s0[3], s1[3], cr[3], nv[3];
    longint c, xv, yv, dot;
    bit ok;
    int a, b, e;
    plane_beat_t pb;
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(d[32*i +: 32]));
      fwd[i] = longint'($signed(d[32*(3+i) +: 32]));
      up[i]  = longint'($signed(d[32*(6+i) +: 32]));
      rt[i]  = longint'($signed(d[32*(9+i) +: 32]));
    end
    unit_vec(fwd, f, ok);
    cd[0] = near_d;
    cd[1] = far_d;
    for (int k = 0; k < 2; k++) begin
      yh[k] = qmul(cd[k], tan_h);
      xh[k] = qmul(yh[k], aspect);
    end
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        c  = clamp(pos[i] + qmul(f[i], cd[k >> 2]));
        xv = qmul(xh[k >> 2], rt[i]);
        yv = qmul(yh[k >> 2], up[i]);
        c = (k & 2) ? clamp(c + xv) : clamp(c - xv);
        c = (k & 1) ? clamp(c + yv) : clamp(c - yv);
        crn[k][i] = c;
      end
    end
    for (int p = 0; p < 6; p++) begin
      e = plane_corner(p, 0);
      a = plane_corner(p, 1);
      b = plane_corner(p, 2);
      for (int i = 0; i < 3; i++) begin
        d0[i] = clamp(crn[a][i] - crn[e][i]);
        d1[i] = clamp(crn[b][i] - crn[e][i]);
      end
      scale_vec(d0, s0);
      scale_vec(d1, s1);
      cr[0] = s0[1] * s1[2] - s0[2] * s1[1];
      cr[1] = s0[2] * s1[0] - s0[0] * s1[2];
      cr[2] = s0[0] * s1[1] - s0[1] * s1[0];
      unit_vec(cr, nv, ok);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += qmul(nv[i], crn[e][i]);
      pb.idx = 3'(p);
      pb.nx = nv[0][31:0];
      pb.ny = nv[1][31:0];
      pb.nz = nv[2][31:0];
      pb.off = 32'(clamp(-dot));
      pb.degen = !ok;
      pb.last = (p == PL_FAR);
      plane_q.push_back(pb);
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic [IN_W-1:0] nd;
    logic nv;
    nd = in_tdata;
    nv = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_planes(pose_q.pop_front());
        poses_sent++;
        nv = 1'b0;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          nv = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 11) - 1;
          nv = 1'b0;
        end else if (pose_q.size() > 0) begin
          nv = 1'b1;
          nd = pose_q[0];
        end else begin
          nv = 1'b0;
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // monitor
  always @(posedge clk) begin
    plane_beat_t w;
    logic nr;
    nr = out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        planes_seen++;
        if (out_tuser[3]) degen_seen++;
        if (plane_q.size() == 0) begin
          $display("%0t: unexpected plane beat %h", $time, out_tdata);
          errors++;
        end else begin
          w = plane_q.pop_front();
          if (out_tuser[2:0] !== w.idx) begin
            $display("%0t: plane_index exp %0d got %0d", $time, w.idx, out_tuser[2:0]);
            errors++;
          end
          if (out_tdata[31:0] !== w.nx) begin
            $display("%0t: normal_x exp %h got %h", $time, w.nx, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== w.ny) begin
            $display("%0t: normal_y exp %h got %h", $time, w.ny, out_tdata[63:32]);
            errors++;
          end
          if (out_tdata[95:64] !== w.nz) begin
            $display("%0t: normal_z exp %h got %h", $time, w.nz, out_tdata[95:64]);
            errors++;
          end
          if (out_tdata[127:96] !== w.off) begin
            $display("%0t: plane_offset exp %h got %h", $time, w.off, out_tdata[127:96]);
            errors++;
          end
          if (out_tuser[3] !== w.degen) begin
            $display("%0t: degenerate exp %b got %b", $time, w.degen, out_tuser[3]);
            errors++;
          end
          if (out_tlast !== w.last) begin
            $display("%0t: last_plane exp %b got %b", $time, w.last, out_tlast);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 11) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    out_tready <= nr;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_pose(logic [31:0] v[12]);
    logic [IN_W-1:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = v[i];
    return d;
  endfunction

  function automatic logic [IN_W-1:0] random_pose();
    logic [31:0] v[12];
    int kind, a, b, c;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) v[i] = $urandom;
    if (kind < 4) begin
      // axis-aligned orthonormal camera with random placement
      a = $urandom_range(0, 2);
      b = (a + 1 + $urandom_range(0, 1)) % 3;
      c = 3 - a - b;
      for (int i = 0; i < 3; i++) v[i] = 32'($signed(v[i]) >>> $urandom_range(4, 14));
      for (int i = 3; i < 12; i++) v[i] = '0;
      v[3 + a] = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      v[6 + b] = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      v[9 + c] = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    end else if (kind < 8) begin
      for (int i = 0; i < 3; i++) v[i] = 32'($signed(v[i]) >>> $urandom_range(6, 16));
      for (int i = 3; i < 12; i++) v[i] = 32'($signed(v[i]) >>> $urandom_range(12, 15));
    end
    return pack_pose(v);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [RW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NEAR: near_d = val;
      REG_FAR:  far_d = val;
      REG_TAN:  tan_h = val;
      default:  aspect = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pose_q.size() > 0 || in_tvalid || plane_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic load_regs(logic [RW-1:0] n, f, t, a);
    write_reg(REG_NEAR, n);
    write_reg(REG_FAR, f);
    write_reg(REG_TAN, t);
    write_reg(REG_ASPECT, a);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pose_q.push_back(random_pose());
    drain();
  endtask

  initial begin
    logic [31:0] v[12];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // standard camera looking down +z, zero forward, zero basis, extremes
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
          32'h0001_0000, 32'h0, 32'h0};
    pose_q.push_back(pack_pose(v));
    v[3] = 0; v[4] = 0; v[5] = 0;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = (i < 6) ? 32'h0001_2345 * (i + 1) : 32'h0;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = 32'h7FFF_FFFF;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = 32'h8000_0000;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
    pose_q.push_back(pack_pose(v));
    for (int i = 0; i < 12; i++) v[i] = 32'hFFFF_FFFF;
    pose_q.push_back(pack_pose(v));
    v = '{32'h7FFF_0000, 32'h8001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0};
    pose_q.push_back(pack_pose(v));
    drain();
    run_random(30);

    load_regs(31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    pose_q.push_back(pack_pose(v));
    run_random(35);
    load_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd1);
    run_random(30);
    load_regs(31'd0, 31'd0, 31'd65536, 31'd0);
    run_random(20);
    load_regs(31'd65536, 31'd6553600, 31'd65536, 31'd116508);
    run_random(40);
    load_regs($urandom, $urandom, $urandom_range(0, 200000), $urandom_range(1, 200000));
    run_random(40);
    load_regs($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 27),
              $urandom_range(0, 1 << 18), $urandom_range(1, 1 << 18));
    quiet = 1;
    run_random(45);

    $display("poses %0d, plane beats %0d (%0d degenerate), seven register settings",
             poses_sent, planes_seen, degen_seen);
    $display("stimulus: axis-aligned cameras, scaled and raw random poses, field extremes");
    if (errors == 0 && plane_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> view_frustum_plane_builder.f
hw/rtl/vfpb_pkg.sv
hw/rtl/vfpb_norm.sv
hw/rtl/view_frustum_plane_builder.sv
dv/tb_view_frustum_plane_builder.sv
